[src/gjmi_pkg.sv]
// shared types and constants for the gauss-jordan matrix inverter
package gjmi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SizeW = 4;
  localparam logic [SizeW-1:0] SizeReset = 4'd6;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StLoad  = 6'b000010,
    StPivot = 6'b000100,
    StCol   = 6'b001000,
    StRest  = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [71:0] v);
    logic signed [DataW-1:0] r;
    if (v > 72'(SatMax)) begin
      r = SatMax;
    end else if (v < 72'(SatMin)) begin
      r = SatMin;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

[src/gjmi_div_cell.sv]
// one cell of a restoring divider chain: handles one quotient bit per cycle
module gjmi_div_cell #(
  parameter int unsigned NumW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [NumW-1:0] rem_i,
  input  logic [NumW-1:0] quo_i,
  input  logic [31:0]     den_i,
  output logic            vld_o,
  output logic [NumW-1:0] rem_o,
  output logic [NumW-1:0] quo_o,
  output logic [31:0]     den_o
);

  logic [NumW-1:0] rem_d, quo_d;
  logic [NumW:0]   trial;
  logic            vld_q;
  logic [NumW-1:0] rem_q, quo_q;
  logic [31:0]     den_q;

  always_comb begin
    trial = {rem_i, quo_i[NumW-1]} - {{(NumW-31){1'b0}}, den_i};
    if (!trial[NumW]) begin
      rem_d = trial[NumW-1:0];
      quo_d = {quo_i[NumW-2:0], 1'b1};
    end else begin
      rem_d = {rem_i[NumW-2:0], quo_i[NumW-1]};
      quo_d = {quo_i[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_i;
  end

  assign vld_o = vld_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

[src/gjmi_div_chain.sv]
// chain of divider cells, a cell per quotient bit, plus sign handling
module gjmi_div_chain #(
  parameter int unsigned NumW = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic signed [NumW-1:0]   num_i,
  input  logic signed [31:0]       den_i,
  output logic                     vld_o,
  output logic signed [NumW-1:0]   quo_o
);

  logic [NumW-1:0] rem_c [NumW+1];
  logic [NumW-1:0] quo_c [NumW+1];
  logic [31:0]     den_c [NumW+1];
  logic            vld_c [NumW+1];
  logic            neg_q [NumW+1];

  assign vld_c[0] = vld_i;
  assign rem_c[0] = '0;
  assign quo_c[0] = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign den_c[0] = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign neg_q[0] = num_i[NumW-1] ^ den_i[31];

  for (genvar g = 0; g < NumW; g++) begin : g_cell
    gjmi_div_cell #(.NumW(NumW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (vld_c[g]),
      .rem_i (rem_c[g]),
      .quo_i (quo_c[g]),
      .den_i (den_c[g]),
      .vld_o (vld_c[g+1]),
      .rem_o (rem_c[g+1]),
      .quo_o (quo_c[g+1]),
      .den_o (den_c[g+1])
    );
    always_ff @(posedge clk_i) begin
      neg_q[g+1] <= neg_q[g];
    end
  end

  assign vld_o = vld_c[NumW];
  assign quo_o = neg_q[NumW] ? -$signed(quo_c[NumW]) : $signed(quo_c[NumW]);

endmodule

[src/gauss_jordan_matrix_inverse_unit.sv]
// top level: gauss-jordan in-place matrix inverter, signed q fixed point
// the first result follows the last element (earlier on a zero pivot), then the n*n results
//   stream out back to back; each divide waits for the divider chain
// throughput: one matrix at a time; busy is high from the cycle after the last element
//   and is low again by the final result strobe; busy stays low while elements load
// reset: asynchronous active low, size returns to 6, load count to zero; no receiver stall
module gauss_jordan_matrix_inverse_unit #(
  parameter int unsigned MAX_N     = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] elem_value_i,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  output logic               strobe,
  output logic signed [31:0] inv_value_o,
  output logic               zero_pivot_o,
  output logic               last_out_o
);

  localparam int unsigned Depth = MAX_N * MAX_N;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned IdxW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned NumW  = 64;

  gjmi_pkg::state_e state_q, state_d;
  logic [3:0]        size_q;
  logic [CntW-1:0]   load_q;
  logic [IdxW:0]     n_w;
  logic [CntW-1:0]   total_w;
  logic [IdxW-1:0]   k_q, i_q, j_q;
  logic [2:0]        ph_q;
  logic              bad_q;
  logic signed [31:0] piv_q, rk_q, cik_q, a_q, b_q;
  logic signed [31:0] mem [Depth];
  logic signed [31:0] rd_q;
  logic [AddrW-1:0]  ra, wa;
  logic              we;
  logic signed [31:0] wd;
  logic              dv_i, dv_o;
  logic signed [NumW-1:0] dnum, dquo;
  logic signed [31:0] dden;
  logic [CntW-1:0]   eidx_q;
  logic              emit_q;
  logic signed [63:0] prod_q;

  always_comb begin
    if (size_q == 4'd0) begin
      n_w = (IdxW+1)'(1);
    end else if (size_q > 4'(MAX_N)) begin
      n_w = (IdxW+1)'(MAX_N);
    end else begin
      n_w = (IdxW+1)'(size_q);
    end
    total_w = CntW'(n_w) * CntW'(n_w);
  end

  function automatic logic [AddrW-1:0] addr(input logic [IdxW-1:0] r, input logic [IdxW-1:0] c,
                                             input logic [IdxW:0] n);
    return AddrW'(CntW'(r) * CntW'(n) + CntW'(c));
  endfunction

  gjmi_div_chain #(.NumW(NumW)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (dv_i),
    .num_i (dnum),
    .den_i (dden),
    .vld_o (dv_o),
    .quo_o (dquo)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  logic [IdxW-1:0] k_d, i_d, j_d;
  logic [2:0]      ph_d;
  logic            bad_d;
  logic [CntW-1:0] load_d, eidx_d;
  logic            emit_d;
  logic signed [31:0] piv_d, rk_d, cik_d, a_d, b_d;
  logic [IdxW-1:0] rowk_last;
  logic [IdxW-1:0] knext, inext;

  assign rowk_last = IdxW'(n_w - (IdxW+1)'(1));
  assign knext     = (k_q == rowk_last) ? '0 : k_q + IdxW'(1);
  assign inext     = (i_q == rowk_last) ? '0 : i_q + IdxW'(1);

  // phases step each state through memory reads, divider or multiply waits and the write back
  always_comb begin
    state_d = state_q;
    k_d = k_q; i_d = i_q; j_d = j_q; ph_d = ph_q; bad_d = bad_q;
    load_d = load_q; eidx_d = eidx_q; emit_d = 1'b0;
    piv_d = piv_q; rk_d = rk_q; cik_d = cik_q; a_d = a_q; b_d = b_q;
    ra = '0; wa = '0; we = 1'b0; wd = '0;
    dv_i = 1'b0; dnum = '0; dden = piv_q;
    case (state_q)
      gjmi_pkg::StIdle, gjmi_pkg::StLoad: begin
        if (start) begin
          we = 1'b1; wa = AddrW'(load_q); wd = elem_value_i;
          if (load_q + CntW'(1) >= total_w) begin
            load_d = '0; state_d = gjmi_pkg::StPivot;
            k_d = '0; ph_d = '0; bad_d = 1'b0;
          end else begin
            load_d = load_q + CntW'(1); state_d = gjmi_pkg::StLoad;
          end
        end
      end
      gjmi_pkg::StPivot: begin
        ra = addr(k_q, k_q, n_w);
        case (ph_q)
          3'd0: ph_d = 3'd1;
          3'd1: begin
            piv_d = rd_q;
            if (rd_q == 0) begin
              bad_d = 1'b1; state_d = gjmi_pkg::StEmit; eidx_d = '0;
            end else begin
              ph_d = 3'd2;
            end
          end
          3'd2: begin
            dv_i = 1'b1;
            dnum = NumW'(64'sd1 <<< (2 * FRAC_BITS));
            ph_d = 3'd3;
          end
          3'd3: begin
            if (dv_o) begin
              rk_d = gjmi_pkg::sat32(72'(dquo));
              i_d = '0; ph_d = '0; state_d = gjmi_pkg::StCol;
            end
          end
          default: ph_d = '0;
        endcase
      end
      gjmi_pkg::StCol: begin
        ra = addr(i_q, k_q, n_w);
        case (ph_q)
          3'd0: begin
            if (i_q == k_q) begin
              ph_d = 3'd4;
            end else begin
              ph_d = 3'd1;
            end
          end
          3'd1: begin
            dv_i = 1'b1;
            dnum = -(NumW'(rd_q) <<< FRAC_BITS);
            ph_d = 3'd2;
          end
          3'd2: begin
            if (dv_o) begin
              we = 1'b1; wa = addr(i_q, k_q, n_w);
              wd = gjmi_pkg::sat32(72'(dquo));
              ph_d = 3'd4;
            end
          end
          default: begin
            if (i_q == rowk_last) begin
              we = 1'b1; wa = addr(k_q, k_q, n_w); wd = rk_q;
              i_d = knext; j_d = '0; ph_d = '0; state_d = gjmi_pkg::StRest;
            end else begin
              i_d = i_q + IdxW'(1); ph_d = '0;
            end
          end
        endcase
      end
      gjmi_pkg::StRest: begin
        // i == k row scaling, else rank-one update; row k comes last so it is read unscaled
        case (ph_q)
          3'd0: begin
            ra = addr(i_q, k_q, n_w);
            if (j_q == k_q) ph_d = 3'd6; else ph_d = 3'd1;
          end
          3'd1: begin
            cik_d = rd_q; ra = addr(k_q, j_q, n_w); ph_d = 3'd2;
          end
          3'd2: begin
            b_d = rd_q; ra = addr(i_q, j_q, n_w); ph_d = 3'd3;
          end
          3'd3: begin
            a_d = rd_q; ph_d = 3'd4;
          end
          3'd4: ph_d = 3'd5;
          3'd5: begin
            we = 1'b1; wa = addr(i_q, j_q, n_w);
            if (i_q == k_q) begin
              wd = gjmi_pkg::sat32(72'(prod_q));
            end else begin
              wd = gjmi_pkg::sat32(72'(a_q) + 72'(prod_q));
            end
            ph_d = 3'd6;
          end
          default: begin
            ph_d = '0;
            if (j_q == rowk_last) begin
              j_d = '0;
              if (i_q == k_q) begin
                i_d = '0;
                if (k_q == rowk_last) begin
                  state_d = gjmi_pkg::StEmit; eidx_d = '0;
                end else begin
                  k_d = k_q + IdxW'(1); state_d = gjmi_pkg::StPivot;
                end
              end else begin
                i_d = inext;
              end
            end else begin
              j_d = j_q + IdxW'(1);
            end
          end
        endcase
      end
      gjmi_pkg::StEmit: begin
        ra = AddrW'(eidx_q);
        emit_d = 1'b1;
        if (eidx_q + CntW'(1) >= total_w) begin
          state_d = gjmi_pkg::StIdle;
        end else begin
          eidx_d = eidx_q + CntW'(1);
        end
      end
      default: state_d = gjmi_pkg::StIdle;
    endcase
    if (cfg_we_i) begin
      load_d = '0;
    end
  end

  // product stage: row k is scaled by rk, other rows use b * cik
  logic signed [63:0] pm, pm_adj;
  always_comb begin
    if (i_q == k_q) pm = 64'(a_q) * 64'(rk_q);
    else            pm = 64'(b_q) * 64'(cik_q);
    // bias negative products so the shift truncates toward zero
    pm_adj = pm[63] ? pm + ((64'sd1 <<< FRAC_BITS) - 64'sd1) : pm;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pm_adj >>> FRAC_BITS;
    piv_q <= piv_d; rk_q <= rk_d; cik_q <= cik_d; a_q <= a_d; b_q <= b_d;
  end

  logic             elast_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gjmi_pkg::StIdle;
      size_q  <= gjmi_pkg::SizeReset;
      load_q  <= '0;
      k_q <= '0; i_q <= '0; j_q <= '0; ph_q <= '0; bad_q <= 1'b0;
      eidx_q <= '0; emit_q <= 1'b0; elast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      load_q <= load_d;
      k_q <= k_d; i_q <= i_d; j_q <= j_d; ph_q <= ph_d; bad_q <= bad_d;
      eidx_q <= eidx_d; emit_q <= emit_d;
      elast_q <= emit_d && (eidx_q + CntW'(1) >= total_w);
    end
  end

  assign busy         = (state_q != gjmi_pkg::StIdle) && (state_q != gjmi_pkg::StLoad);
  assign strobe       = emit_q;
  assign inv_value_o  = bad_q ? 32'sd0 : rd_q;
  assign zero_pivot_o = bad_q;
  assign last_out_o   = elast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) last_out_o |-> strobe)
    else $error("last without strobe");
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe |-> !$past(start && !busy))
    else $error("result during load");
  assert property (@(posedge clk_i) disable iff (!rst_ni) last_out_o |=> !strobe)
    else $error("result after last");

endmodule

[tb/sv/gauss_jordan_matrix_inverse_unit_tb.sv]
// testbench for the gauss-jordan matrix inverter: loads matrices and checks the inverses
module gauss_jordan_matrix_inverse_unit_tb;

  localparam int Period = 12;
  localparam int WdLimit = 60000;
  localparam int QuietMin = 8;

  typedef enum logic [1:0] {KElem, KSize, KHold} kind_e;

  typedef struct {
    kind_e             kind;
    logic signed [31:0] val;
    logic [3:0]        size;
  } stim_t;

  typedef struct {
    logic signed [31:0] v;
    logic               zp;
    logic               last;
  } inv_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] elem_value_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [3:0]         cfg_wdata_i = '0;
  logic               strobe;
  logic signed [31:0] inv_value_o;
  logic               zero_pivot_o;
  logic               last_out_o;

  stim_t    pend_q[$];
  inv_res_t inv_exp_q[$];
  int       errors = 0;
  int       quiet = 0;
  int       wd_cnt = 0;
  int       gap_left = 0;
  int       burst_left = 0;

  logic signed [31:0] mat[64];
  int                 ld_cnt = 0;
  logic [3:0]         mat_size = gjmi_pkg::SizeReset;

  gauss_jordan_matrix_inverse_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .elem_value_i(elem_value_i), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .strobe(strobe), .inv_value_o(inv_value_o), .zero_pivot_o(zero_pivot_o),
    .last_out_o(last_out_o)
  );

  always begin
    #(Period / 2) clk_i = 1'b1;
    #(Period / 2) clk_i = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic int order_n();
    if (mat_size == 4'd0) return 1;
    if (mat_size > 4'd8) return 8;
    return int'(mat_size);
  endfunction

  function automatic bit invert_in_place(int n);
    logic signed [31:0] p, rk, cik;
    for (int k = 0; k < n; k++) begin
      p = mat[(k * n + k) & 63];
      if (p == 0) return 1'b1;
      for (int i = 0; i < n; i++)
        if (i != k) mat[(i * n + k) & 63] =
            clamp32((-longint'(mat[(i * n + k) & 63]) * 65536) / longint'(p));
      rk = clamp32((64'sd1 <<< 32) / longint'(p));
      mat[(k * n + k) & 63] = rk;
      for (int i = 0; i < n; i++) begin
        if (i == k) continue;
        cik = mat[(i * n + k) & 63];
        for (int j = 0; j < n; j++) begin
          if (j == k) continue;
          mat[(i * n + j) & 63] = clamp32(longint'(mat[(i * n + j) & 63]) +
              (longint'(mat[(k * n + j) & 63]) * longint'(cik)) / 65536);
        end
      end
      for (int j = 0; j < n; j++)
        if (j != k) mat[(k * n + j) & 63] =
            clamp32((longint'(mat[(k * n + j) & 63]) * longint'(rk)) / 65536);
    end
    return 1'b0;
  endfunction

  function automatic void load_elem(logic signed [31:0] v);
    int n;
    bit bad;
    inv_res_t r;
    n = order_n();
    mat[ld_cnt & 63] = v;
    ld_cnt = (ld_cnt + 1) & 127;
    if (ld_cnt < n * n) return;
    ld_cnt = 0;
    bad = invert_in_place(n);
    for (int e = 0; e < n * n; e++) begin
      r.v = bad ? 32'sd0 : mat[e & 63];
      r.zp = bad;
      r.last = (e + 1 == n * n);
      inv_exp_q.push_back(r);
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t it;
    logic nxt_start, nxt_we;
    logic signed [31:0] nxt_val;
    logic [3:0] nxt_wd;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_val = elem_value_i;
      nxt_we = 1'b0;
      nxt_wd = cfg_wdata_i;
      if (start && !busy) begin
        load_elem(elem_value_i);
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          it = pend_q[0];
          if (it.kind == KElem) begin
            void'(pend_q.pop_front());
            nxt_start = 1'b1;
            nxt_val = it.val;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 16);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
              burst_left--;
            end
          end else if (inv_exp_q.size() == 0 && !busy && quiet >= QuietMin) begin
            void'(pend_q.pop_front());
            if (it.kind == KSize) begin
              nxt_we = 1'b1;
              nxt_wd = it.size;
              mat_size = it.size;
              ld_cnt = 0;
            end
          end
        end
      end
      start <= nxt_start;
      elem_value_i <= nxt_val;
      cfg_we_i <= nxt_we;
      cfg_wdata_i <= nxt_wd;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    inv_res_t r;
    quiet <= (inv_exp_q.size() == 0 && !busy && !start && !cfg_we_i) ? quiet + 1 : 0;
    if (rst_ni && strobe) begin
      if (inv_exp_q.size() == 0) begin
        $error("unexpected transaction inv_value=%0d", inv_value_o);
        errors++;
      end else begin
        r = inv_exp_q.pop_front();
        if (inv_value_o !== r.v) begin
          $error("inv_value expected %0d actual %0d", r.v, inv_value_o);
          errors++;
        end
        if (zero_pivot_o !== r.zp) begin
          $error("zero_pivot expected %0b actual %0b", r.zp, zero_pivot_o);
          errors++;
        end
        if (last_out_o !== r.last) begin
          $error("last_out expected %0b actual %0b", r.last, last_out_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe || cfg_we_i || !rst_ni) wd_cnt <= 0;
    else wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WdLimit) begin
      $display("FAIL gauss_jordan_matrix_inverse_unit");
      $finish;
    end
  end

  function automatic void put_size(logic [3:0] s);
    stim_t it;
    it.kind = KSize;
    it.size = s;
    it.val = '0;
    pend_q.push_back(it);
  endfunction

  function automatic void put_elem(logic signed [31:0] v);
    stim_t it;
    it.kind = KElem;
    it.val = v;
    it.size = '0;
    pend_q.push_back(it);
  endfunction

  function automatic void put_hold();
    stim_t it;
    it.kind = KHold;
    it.val = '0;
    it.size = '0;
    pend_q.push_back(it);
  endfunction

  // flavor 0 large diagonal with small off-diagonal terms, 1 raw bits, 2 zero leading pivot, 3 extremes
  function automatic void put_matrix(int n, int flavor);
    logic signed [31:0] v;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        case (flavor)
          0: begin
            if (i == j) begin
              v = $urandom_range(1 << 16, 20 << 16);
              if ($urandom_range(0, 1)) v = -v;
            end else begin
              v = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
            end
          end
          1: v = $urandom;
          2: v = (i == 0 && j == 0) ? 32'sd0 : $signed($urandom_range(0, 1 << 18));
          default: begin
            case ($urandom_range(0, 3))
              0: v = 32'sh7fff_ffff;
              1: v = 32'sh8000_0000;
              2: v = 32'sd1;
              default: v = $urandom;
            endcase
          end
        endcase
        put_elem(v);
      end
  endfunction

  initial begin
    int n_items, n, flv;
    logic [3:0] s;
    put_size(4'd1);
    put_elem(32'sh7fff_ffff);
    put_elem(32'sh8000_0000);
    put_elem(32'sd0);
    put_elem(32'sd1);
    put_elem(32'sh0001_0000);
    put_elem(-32'sd1);
    put_size(4'd0);
    put_elem(32'sh0002_0000);
    put_size(4'd3);
    put_elem(32'sh0001_0000);
    put_elem(32'sh0005_0000);
    put_size(4'd2);
    put_matrix(2, 0);
    put_matrix(2, 2);
    put_hold();
    put_size(4'd15);
    put_matrix(8, 0);
    n_items = 0;
    while (n_items < 380) begin
      case ($urandom_range(0, 9))
        0: s = 4'd0;
        1: s = $urandom_range(4, 8);
        2: s = $urandom_range(9, 15);
        default: s = $urandom_range(1, 3);
      endcase
      if (s > 4'd3 && $urandom_range(0, 2) != 0) s = 4'd2;
      put_size(s);
      n = (s == 0) ? 1 : (s > 8) ? 8 : int'(s);
      for (int m = $urandom_range(1, 4); m > 0; m--) begin
        flv = $urandom_range(0, 9);
        flv = (flv < 6) ? 0 : (flv == 6) ? 1 : (flv == 7) ? 2 : 3;
        put_matrix(n, flv);
        n_items += n * n;
        if ($urandom_range(0, 15) == 0) put_hold();
      end
      if ($urandom_range(0, 7) == 0) begin
        for (int m = $urandom_range(1, n * n); m > 1; m--) put_elem($urandom);
        n_items += n * n;
      end
    end
    put_size(4'd8);
    put_matrix(8, 1);
    put_size(4'd1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pend_q.size() != 0 || start || cfg_we_i || inv_exp_q.size() != 0 || busy);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS gauss_jordan_matrix_inverse_unit");
    end else begin
      $display("FAIL gauss_jordan_matrix_inverse_unit");
    end
    $finish;
  end

endmodule

[files.f]
src/gjmi_pkg.sv
src/gjmi_div_cell.sv
src/gjmi_div_chain.sv
src/gauss_jordan_matrix_inverse_unit.sv
tb/sv/gauss_jordan_matrix_inverse_unit_tb.sv
